[hdl/mmgm_pkg.sv]
package mmgm_pkg;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic KIND_GRAY  = 1'b0;
    localparam logic KIND_RANGE = 1'b1;

    localparam logic [1:0] REG_FIXED_EN   = 2'd0;
    localparam logic [1:0] REG_FIXED_LOW  = 2'd1;
    localparam logic [1:0] REG_FIXED_HIGH = 2'd2;

    localparam logic [7:0] GRAY_MID  = 8'd128;
    localparam logic [7:0] GRAY_FULL = 8'd255;
    localparam logic [7:0] GRAY_ZERO = 8'd0;

    // Quotient bits produced by the divider: 255*d/r < 255 fits in 8 bits
    localparam int QBITS = 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic measure;   // update running min/max with the input beat
        logic latch;     // latch held range and restart running range
        logic conv_load; // capture convert operands and start division
        logic div_step;  // one restoring division step
        logic emit_rng;  // load output with a range report
        logic emit_gray; // load output with the gray result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic trivial;   // gray known without dividing
        logic div_done;  // last quotient bit produced
    } t_sts;

endpackage

[hdl/mmgm_dp.sv]
module mmgm_dp #(
    parameter int AMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mmgm_pkg::t_cmd        i_cmd,
    output mmgm_pkg::t_sts        o_sts,
    input  logic                  i_fixed_en,
    input  logic [AMP_WIDTH-1:0]  i_fixed_low,
    input  logic [AMP_WIDTH-1:0]  i_fixed_high,
    input  logic [AMP_WIDTH-1:0]  i_amplitude,
    input  logic                  i_captured,
    output logic                  o_kind,
    output logic [7:0]            o_gray,
    output logic [AMP_WIDTH-1:0]  o_range_low,
    output logic [AMP_WIDTH-1:0]  o_range_high,
    output logic                  o_range_empty
);
    import mmgm_pkg::*;

    localparam int DW = AMP_WIDTH + 8;
    localparam int CW = $clog2(QBITS + 2);
    localparam logic [AMP_WIDTH-1:0] SIGN = {1'b1, {(AMP_WIDTH-1){1'b0}}};

    logic [AMP_WIDTH-1:0] r_run_min, r_run_max, r_held_min, r_held_max;
    logic                 r_run_any, r_held_empty;
    logic [DW-1:0]        r_num;   // 255*d, shifted out from the top
    logic [AMP_WIDTH:0]   r_rem;
    logic [AMP_WIDTH-1:0] r_den;
    logic [7:0]           r_q;
    logic [CW-1:0]        r_cnt;
    logic                 r_triv;
    logic [7:0]           r_triv_val;

    logic [AMP_WIDTH-1:0] kx, kl, kh, rng_lo, rng_hi, d;
    logic                 rng_empty;
    logic [AMP_WIDTH:0]   rem_sh, rem_sub;
    logic [AMP_WIDTH+1:0] rem2;

    // Order-preserving keys by flipping the sign bit
    assign rng_lo    = i_fixed_en ? i_fixed_low  : r_held_min;
    assign rng_hi    = i_fixed_en ? i_fixed_high : r_held_max;
    assign rng_empty = !i_fixed_en && r_held_empty;
    assign kx = i_amplitude ^ SIGN;
    assign kl = rng_lo ^ SIGN;
    assign kh = rng_hi ^ SIGN;
    assign d  = kx - kl;

    // Running range over captured measure beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min    <= ~SIGN;
            r_run_max    <= SIGN;
            r_run_any    <= 1'b0;
            r_held_min   <= '0;
            r_held_max   <= '0;
            r_held_empty <= 1'b1;
        end else if (i_cmd.latch) begin
            r_held_empty <= !(r_run_any || i_captured);
            if (r_run_any || i_captured) begin
                r_held_min <= (i_captured && (kx < (r_run_min ^ SIGN))) ?
                              i_amplitude : r_run_min;
                r_held_max <= (i_captured && (kx > (r_run_max ^ SIGN))) ?
                              i_amplitude : r_run_max;
            end else begin
                r_held_min <= '0;
                r_held_max <= '0;
            end
            r_run_min <= ~SIGN;
            r_run_max <= SIGN;
            r_run_any <= 1'b0;
        end else if (i_cmd.measure && i_captured) begin
            if (kx < (r_run_min ^ SIGN)) r_run_min <= i_amplitude;
            if (kx > (r_run_max ^ SIGN)) r_run_max <= i_amplitude;
            r_run_any <= 1'b1;
        end
    end

    // Restoring division step: shift one numerator bit into the remainder
    assign rem_sh  = {r_rem[AMP_WIDTH-1:0], r_num[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign rem2    = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.conv_load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.conv_load) begin
            // quotient of 255*d/r fits 8 bits; top AMP_WIDTH bits give zero
            r_num <= ({8'd0, d} << 8) - {8'd0, d};
            r_den <= kh - kl;
            r_rem <= '0;
            r_q   <= '0;
            r_triv <= rng_empty || (kh <= kl) || (kx <= kl) || (kx >= kh);
            if (rng_empty)      r_triv_val <= GRAY_ZERO;
            else if (kh <= kl)  r_triv_val <= GRAY_MID;
            else if (kx <= kl)  r_triv_val <= GRAY_ZERO;
            else if (kx >= kh)  r_triv_val <= GRAY_FULL;
            else                r_triv_val <= GRAY_ZERO;
        end else if (i_cmd.div_step) begin
            if (r_cnt == '0) begin
                // preload top AMP_WIDTH numerator bits (always below r)
                r_rem <= {1'b0, r_num[DW-1:8]};
                r_num <= {r_num[7:0], {AMP_WIDTH{1'b0}}};
            end else begin
                r_num <= r_num << 1;
                r_q <= {r_q[6:0], (rem_sub[AMP_WIDTH] == 1'b0)};
                r_rem <= (rem_sub[AMP_WIDTH] == 1'b0) ? rem_sub : rem_sh;
            end
        end
    end

    // One preload step, then one step per quotient bit
    assign o_sts.trivial  = r_triv;
    assign o_sts.div_done = (r_cnt == CW'(QBITS + 1));

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rng) begin
            o_kind  <= KIND_RANGE;
            o_gray  <= GRAY_ZERO;
            if (i_fixed_en) begin
                o_range_low   <= i_fixed_low;
                o_range_high  <= i_fixed_high;
                o_range_empty <= 1'b0;
            end else begin
                o_range_low   <= r_held_min;
                o_range_high  <= r_held_max;
                o_range_empty <= r_held_empty;
            end
        end else if (i_cmd.emit_gray) begin
            o_kind        <= KIND_GRAY;
            o_range_low   <= '0;
            o_range_high  <= '0;
            o_range_empty <= 1'b0;
            if (r_triv) o_gray <= r_triv_val;
            else        o_gray <= r_q + {7'd0, (rem2 >= {2'b0, r_den})};
        end
    end

endmodule

[hdl/mmgm_ctrl.sv]
module mmgm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_opcode,
    input  logic           i_last,
    output logic           o_valid,
    input  logic           i_stall,
    output mmgm_pkg::t_cmd o_cmd,
    input  mmgm_pkg::t_sts i_sts
);
    import mmgm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RNG  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       acc, out_free;

    // Output slot frees when empty or being taken this edge
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign acc      = i_valid && !o_stall;
    assign o_valid  = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_opcode == OP_CONVERT) begin
                        o_cmd.conv_load = 1'b1;
                        n_state = S_CHK;
                    end else begin
                        o_cmd.measure = 1'b1;
                        o_cmd.latch   = i_last;
                        if (i_last) n_state = S_RNG;
                    end
                end
            end
            S_RNG: begin
                if (out_free) begin
                    o_cmd.emit_rng = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CHK: begin
                if (i_sts.trivial) begin
                    if (out_free) begin
                        o_cmd.emit_gray = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (out_free) begin
                        o_cmd.emit_gray = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

[hdl/masked_min_max_gray_mapper_top.sv]
// Channel | Signals                                          | Direction
// in      | i_valid, o_stall, i_opcode/amplitude/captured/last | into block
// out     | o_valid, i_stall, o_kind/gray/range_*            | out of block
// cfg     | i_cfg_we, i_cfg_index, i_cfg_data                 | into block
// A measure beat with last also emits a range report when output is free.
// A convert beat emits the gray value directly when it needs no division,
// else a restoring divider first produces one quotient bit per cycle.
// Reset is synchronous, active low, and clears control state and ranges.
// A stalled result holds in the output register; input stalls while busy.
module masked_min_max_gray_mapper_top #(
    parameter int AMP_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [AMP_WIDTH-1:0] i_amplitude,
    input  logic                 i_captured,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [7:0]           o_gray,
    output logic [AMP_WIDTH-1:0] o_range_low,
    output logic [AMP_WIDTH-1:0] o_range_high,
    output logic                 o_range_empty,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [AMP_WIDTH-1:0] i_cfg_data
);
    import mmgm_pkg::*;

    logic                 r_fixed_en;
    logic [AMP_WIDTH-1:0] r_fixed_low, r_fixed_high;
    t_cmd                 cmd;
    t_sts                 sts;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_en   <= 1'b0;
            r_fixed_low  <= '0;
            r_fixed_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIXED_EN:   r_fixed_en   <= i_cfg_data[0];
                REG_FIXED_LOW:  r_fixed_low  <= i_cfg_data;
                REG_FIXED_HIGH: r_fixed_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mmgm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_opcode(i_opcode),
        .i_last  (i_last),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    mmgm_dp #(.AMP_WIDTH(AMP_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_fixed_en   (r_fixed_en),
        .i_fixed_low  (r_fixed_low),
        .i_fixed_high (r_fixed_high),
        .i_amplitude  (i_amplitude),
        .i_captured   (i_captured),
        .o_kind       (o_kind),
        .o_gray       (o_gray),
        .o_range_low  (o_range_low),
        .o_range_high (o_range_high),
        .o_range_empty(o_range_empty)
    );

endmodule
